// ----- hw/rtl/kda_pkg.sv -----
package kda_pkg;

  localparam int KEY_COUNT_DEF = 8;
  localparam int MAX_OUT       = 8;
  localparam int CNT_W         = $clog2(MAX_OUT + 1);
  localparam int STEP_W        = 3;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_W         = 16;

  localparam logic [31:0] LAST_RESET   = 32'hFFFF_FFFF - 32'd20;
  localparam logic [15:0] DEBOUNCE_RST = 16'd20;
  localparam logic [15:0] LONG_RST     = 16'd500;
  localparam logic [15:0] REPEAT_RST   = 16'd50;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT   = 2'd2;

  localparam logic [1:0] FUNC_PRESS   = 2'd0;
  localparam logic [1:0] FUNC_RELEASE = 2'd1;
  localparam logic [1:0] FUNC_PASS    = 2'd2;
  localparam logic [1:0] FUNC_TICK    = 2'd3;

  localparam logic [3:0] KIND_PRESS     = 4'd0;
  localparam logic [3:0] KIND_RELEASE   = 4'd1;
  localparam logic [3:0] KIND_REPEAT    = 4'd2;
  localparam logic [3:0] KIND_PASS_BASE = 4'd3;
  localparam logic [2:0] PASS_KIND_MAX  = 3'd5;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  key_num;
    logic [2:0]  pass_kind;
    logic [31:0] event_payload;
    logic [31:0] event_stamp;
    logic [31:0] now_time;
  } in_t;

  typedef struct packed {
    logic [3:0]  out_kind;
    logic [7:0]  out_key;
    logic [31:0] out_payload;
    logic [31:0] out_stamp;
    logic        last_of_run;
  } out_t;

  typedef enum logic [2:0] {
    OP_NOP     = 3'd0,
    OP_LATCH   = 3'd1,
    OP_PRESS   = 3'd2,
    OP_RELEASE = 3'd3,
    OP_PASS    = 3'd4,
    OP_SCAN    = 3'd5,
    OP_FLUSH   = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    J_NEXT     = 2'd0,
    J_GOTO     = 2'd1,
    J_COND     = 2'd2,
    J_DISPATCH = 2'd3
  } jmp_t;

  typedef struct packed {
    logic              accept;
    op_t               op;
    jmp_t              jmp;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic stall;
    logic cond;
    logic pend_v;
  } st_t;

endpackage

// ----- hw/rtl/kda_seq.sv -----
module kda_seq
  import kda_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_func,
  input  st_t        st,
  output ctrl_t      ctrl
);

  localparam logic [STEP_W-1:0] S_IDLE     = 3'd0;
  localparam logic [STEP_W-1:0] S_JT       = 3'd1;  // jump table: press, release, pass, tick
  localparam logic [STEP_W-1:0] S_JT_REL   = 3'd2;
  localparam logic [STEP_W-1:0] S_JT_PASS  = 3'd3;
  localparam logic [STEP_W-1:0] S_TICK_RD  = 3'd4;
  localparam logic [STEP_W-1:0] S_TICK_EV  = 3'd5;
  localparam logic [STEP_W-1:0] S_FIN      = 3'd6;
  localparam logic [STEP_W-1:0] S_PRESS_EV = 3'd7;

  function automatic ctrl_t rom(input logic [STEP_W-1:0] pc);
    ctrl_t w;
    w.accept = 1'b0;
    w.op     = OP_NOP;
    w.jmp    = J_GOTO;
    w.target = S_IDLE;
    case (pc)
      S_IDLE: begin
        w.accept = 1'b1;
        w.op     = OP_LATCH;
        w.jmp    = J_DISPATCH;
        w.target = S_JT;
      end
      S_JT: begin
        w.target = S_PRESS_EV;
      end
      S_JT_REL: begin
        w.op     = OP_RELEASE;
        w.target = S_FIN;
      end
      S_JT_PASS: begin
        w.op     = OP_PASS;
        w.target = S_FIN;
      end
      S_TICK_RD: begin
        w.jmp = J_NEXT;
      end
      S_TICK_EV: begin
        w.op     = OP_SCAN;
        w.jmp    = J_COND;
        w.target = S_TICK_RD;
      end
      S_FIN: begin
        w.op     = OP_FLUSH;
        w.target = S_IDLE;
      end
      S_PRESS_EV: begin
        w.op     = OP_PRESS;
        w.target = S_FIN;
      end
      default: begin
        w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

  logic [STEP_W-1:0] pc_r, pc_nxt;

  assign ctrl = rom(pc_r);

  always_comb begin
    pc_nxt = pc_r;
    if (!st.stall) begin
      case (ctrl.jmp)
        J_NEXT:     pc_nxt = pc_r + STEP_W'(1);
        J_GOTO:     pc_nxt = ctrl.target;
        J_COND:     pc_nxt = st.cond ? ctrl.target : pc_r + STEP_W'(1);
        J_DISPATCH: if (in_valid) pc_nxt = ctrl.target + STEP_W'(in_func);
        default:    pc_nxt = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ----- hw/rtl/kda_mem.sv -----
module kda_mem
  import kda_pkg::*;
#(
  parameter int KEY_COUNT = KEY_COUNT_DEF,
  localparam int KW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [KW-1:0] rd_addr,
  input  logic [KW-1:0] wr_addr,
  input  logic          wr_last_en,
  input  logic [31:0]   wr_last,
  input  logic          wr_dl_en,
  input  logic [31:0]   wr_dl,
  output logic [31:0]   rd_last,
  output logic [31:0]   rd_dl
);

  logic [31:0]          last_mem_r [KEY_COUNT];
  logic [31:0]          dl_mem_r   [KEY_COUNT];
  logic [KEY_COUNT-1:0] seen_r;
  logic                 rd_seen_r;
  logic [31:0]          rd_last_r;
  logic [31:0]          rd_dl_r;

  always_ff @(posedge clk) begin
    if (wr_last_en) last_mem_r[wr_addr] <= wr_last;
    if (wr_dl_en) dl_mem_r[wr_addr] <= wr_dl;
    rd_last_r <= last_mem_r[rd_addr];
    rd_dl_r   <= dl_mem_r[rd_addr];
  end

  // an entry never pressed reads as its reset stamp
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r    <= '0;
      rd_seen_r <= 1'b0;
    end else begin
      if (wr_last_en) seen_r[wr_addr] <= 1'b1;
      rd_seen_r <= seen_r[rd_addr];
    end
  end

  assign rd_last = rd_seen_r ? rd_last_r : LAST_RESET;
  assign rd_dl   = rd_dl_r;

endmodule

// ----- hw/rtl/kda_dp.sv -----
module kda_dp
  import kda_pkg::*;
#(
  parameter int KEY_COUNT = KEY_COUNT_DEF,
  localparam int KW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ctrl_t                ctrl,
  input  logic                 in_valid,
  input  in_t                  in_data,
  input  logic                 out_ready,
  output logic                 out_valid,
  output out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output st_t                  st,
  output logic [KW-1:0]        mem_addr,
  output logic                 wr_last_en,
  output logic [31:0]          wr_last,
  output logic                 wr_dl_en,
  output logic [31:0]          wr_dl,
  input  logic [31:0]          rd_last,
  input  logic [31:0]          rd_dl
);

  in_t                  in_r, in_nxt;
  logic [KW-1:0]        addr_r, addr_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  out_t                 pend_r, pend_nxt;
  logic                 pend_v_r, pend_v_nxt;
  out_t                 out_r, out_nxt;
  logic                 out_v_r, out_v_nxt;
  logic [KEY_COUNT-1:0] held_r, held_nxt;
  logic [15:0]          debounce_r, long_r, repeat_r;

  logic        accept;
  logic        free;
  logic        in_range;
  logic        last_key;
  logic        due;
  logic [31:0] delta;

  assign accept   = ctrl.accept && in_valid;
  assign free     = !out_v_r || out_ready;
  assign in_range = {1'b0, in_r.key_num} < 9'(KEY_COUNT);
  assign last_key = addr_r == KW'(KEY_COUNT - 1);
  assign delta    = in_r.now_time - rd_last;
  assign due      = held_r[addr_r] && (in_r.now_time >= rd_dl);

  assign mem_addr  = addr_r;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  always_comb begin
    in_nxt     = in_r;
    addr_nxt   = addr_r;
    cnt_nxt    = cnt_r;
    pend_nxt   = pend_r;
    pend_v_nxt = pend_v_r;
    out_nxt    = out_r;
    out_v_nxt  = out_v_r && !out_ready;
    held_nxt   = held_r;
    wr_last_en = 1'b0;
    wr_last    = in_r.now_time;
    wr_dl_en   = 1'b0;
    wr_dl      = in_r.now_time + {16'b0, long_r};
    st         = '0;
    st.pend_v  = pend_v_r;

    case (ctrl.op)
      OP_LATCH: begin
        if (accept) begin
          in_nxt   = in_data;
          addr_nxt = (in_data.func == FUNC_TICK) ? '0 : in_data.key_num[KW-1:0];
          cnt_nxt  = '0;
        end
      end
      OP_PRESS: begin
        if (in_range && (delta >= {16'b0, debounce_r})) begin
          wr_last_en           = 1'b1;
          wr_dl_en             = 1'b1;
          held_nxt[addr_r]     = 1'b1;
          pend_nxt.out_kind    = KIND_PRESS;
          pend_nxt.out_key     = in_r.key_num;
          pend_nxt.out_payload = '0;
          pend_nxt.out_stamp   = in_r.event_stamp;
          pend_nxt.last_of_run = 1'b0;
          pend_v_nxt           = 1'b1;
        end
      end
      OP_RELEASE: begin
        if (in_range && held_r[addr_r]) begin
          held_nxt[addr_r]     = 1'b0;
          pend_nxt.out_kind    = KIND_RELEASE;
          pend_nxt.out_key     = in_r.key_num;
          pend_nxt.out_payload = '0;
          pend_nxt.out_stamp   = in_r.event_stamp;
          pend_nxt.last_of_run = 1'b0;
          pend_v_nxt           = 1'b1;
        end
      end
      OP_PASS: begin
        if (in_r.pass_kind <= PASS_KIND_MAX) begin
          pend_nxt.out_kind    = KIND_PASS_BASE + {1'b0, in_r.pass_kind};
          pend_nxt.out_key     = '0;
          pend_nxt.out_payload = in_r.event_payload;
          pend_nxt.out_stamp   = in_r.event_stamp;
          pend_nxt.last_of_run = 1'b0;
          pend_v_nxt           = 1'b1;
        end
      end
      OP_SCAN: begin
        // a repeat waits in the pending slot until the next one shows it was not last
        st.stall = due && pend_v_r && !free;
        st.cond  = !last_key && !(due && cnt_r == CNT_W'(MAX_OUT - 1));
        if (!st.stall) begin
          if (due) begin
            if (pend_v_r) begin
              out_nxt             = pend_r;
              out_nxt.last_of_run = 1'b0;
              out_v_nxt           = 1'b1;
            end
            pend_nxt.out_kind    = KIND_REPEAT;
            pend_nxt.out_key     = 8'(addr_r);
            pend_nxt.out_payload = '0;
            pend_nxt.out_stamp   = in_r.now_time;
            pend_nxt.last_of_run = 1'b0;
            pend_v_nxt           = 1'b1;
            cnt_nxt              = cnt_r + CNT_W'(1);
            wr_dl_en             = 1'b1;
            wr_dl                = in_r.now_time + {16'b0, repeat_r};
          end
          addr_nxt = addr_r + KW'(1);
        end
      end
      OP_FLUSH: begin
        st.stall = pend_v_r && !free;
        if (pend_v_r && free) begin
          out_nxt             = pend_r;
          out_nxt.last_of_run = 1'b1;
          out_v_nxt           = 1'b1;
          pend_v_nxt          = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    in_r   <= in_nxt;
    addr_r <= addr_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      pend_v_r   <= 1'b0;
      out_v_r    <= 1'b0;
      held_r     <= '0;
      debounce_r <= DEBOUNCE_RST;
      long_r     <= LONG_RST;
      repeat_r   <= REPEAT_RST;
    end else begin
      cnt_r    <= cnt_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
      held_r   <= held_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_DEBOUNCE: debounce_r <= cfg_wdata;
          REG_LONG:     long_r     <= cfg_wdata;
          REG_REPEAT:   repeat_r   <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// ----- hw/rtl/key_debounce_autorepeat.sv -----
// Key debounce with typematic auto-repeat. Takes one event at a time (press, release,
// encoder/touch pass-through, or time tick) and delivers zero or more result events, the
// final one flagged by last_of_run. A small control program steps a datapath built around a
// single-port per-key memory holding each key's last accepted press time and next repeat
// deadline. A tick reads and checks each key in two steps through that memory port and
// stops early once 8 repeats are out. Config register writes are registered and apply
// to any event handled after them, including one already in progress.
module key_debounce_autorepeat
  import kda_pkg::*;
#(
  parameter int KEY_COUNT = KEY_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int KW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

  ctrl_t         ctrl;
  st_t           st;
  logic [KW-1:0] mem_addr;
  logic          wr_last_en;
  logic [31:0]   wr_last;
  logic          wr_dl_en;
  logic [31:0]   wr_dl;
  logic [31:0]   rd_last;
  logic [31:0]   rd_dl;

  assign in_ready = ctrl.accept;

  kda_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_data.func),
    .st       (st),
    .ctrl     (ctrl)
  );

  kda_mem #(
    .KEY_COUNT (KEY_COUNT)
  ) u_mem (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_addr    (mem_addr),
    .wr_addr    (mem_addr),
    .wr_last_en (wr_last_en),
    .wr_last    (wr_last),
    .wr_dl_en   (wr_dl_en),
    .wr_dl      (wr_dl),
    .rd_last    (rd_last),
    .rd_dl      (rd_dl)
  );

  kda_dp #(
    .KEY_COUNT (KEY_COUNT)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .st         (st),
    .mem_addr   (mem_addr),
    .wr_last_en (wr_last_en),
    .wr_last    (wr_last),
    .wr_dl_en   (wr_dl_en),
    .wr_dl      (wr_dl),
    .rd_last    (rd_last),
    .rd_dl      (rd_dl)
  );

`ifndef ASSERT_OFF
  ap_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !st.pend_v)
    else $error("input taken while a result is still pending");

  ap_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second transfer accepted right after the first");

  ap_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    st.stall |-> (st.pend_v && out_valid && !out_ready))
    else $error("program held without a blocked output");
`endif

endmodule

// ----- test/key_debounce_autorepeat_tb.sv -----
module key_debounce_autorepeat_tb;
  import kda_pkg::*;

  localparam int KEYS = KEY_COUNT_DEF;
  localparam int SETTLE_CYCLES = 2 * KEYS + 24;
  localparam int HOLD_CYCLES = 300;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

  typedef struct packed {
    logic typed;
    logic has_res;
    out_t res;
  } dir_check_t;

  typedef struct packed {
    in_t        item;
    dir_check_t chk;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  dir_check_t in_chk = '0;

  // key state and register copies
  logic [15:0] bounce_win;
  logic [15:0] hold_delay;
  logic [15:0] rep_period;
  logic        key_held[KEYS];
  logic [31:0] key_last_press[KEYS];
  logic [31:0] key_deadline[KEYS];

  out_t step_res[$];
  out_t events_due[$];
  dir_row_t dir_rows[$];

  int errors = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  logic [31:0] clock_ms = '0;

  key_debounce_autorepeat #(.KEY_COUNT(KEYS)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic in_t pkt(logic [1:0] func, logic [7:0] key, logic [2:0] kind,
                              logic [31:0] payload, logic [31:0] stamp, logic [31:0] now);
    in_t it;
    it.func = func;
    it.key_num = key;
    it.pass_kind = kind;
    it.event_payload = payload;
    it.event_stamp = stamp;
    it.now_time = now;
    return it;
  endfunction

  function automatic out_t ev(logic [3:0] kind, logic [7:0] key, logic [31:0] payload,
                              logic [31:0] stamp, logic last);
    out_t r;
    r.out_kind = kind;
    r.out_key = key;
    r.out_payload = payload;
    r.out_stamp = stamp;
    r.last_of_run = last;
    return r;
  endfunction

  function automatic void predict_events(in_t it);
    int i;
    logic [31:0] gap;
    step_res.delete();
    case (it.func)
      FUNC_PRESS: begin
        if (it.key_num < KEYS) begin
          i = it.key_num;
          gap = it.now_time - key_last_press[i];
          if (gap >= {16'd0, bounce_win}) begin
            key_held[i] = 1'b1;
            key_last_press[i] = it.now_time;
            key_deadline[i] = it.now_time + {16'd0, hold_delay};
            step_res.push_back(ev(KIND_PRESS, it.key_num, '0, it.event_stamp, 1'b0));
          end
        end
      end
      FUNC_RELEASE: begin
        if (it.key_num < KEYS) begin
          i = it.key_num;
          if (key_held[i]) begin
            key_held[i] = 1'b0;
            step_res.push_back(ev(KIND_RELEASE, it.key_num, '0, it.event_stamp, 1'b0));
          end
        end
      end
      FUNC_PASS: begin
        if (it.pass_kind <= PASS_KIND_MAX)
          step_res.push_back(ev(KIND_PASS_BASE + {1'b0, it.pass_kind}, '0,
                                it.event_payload, it.event_stamp, 1'b0));
      end
      default: begin
        // scan ascending, at most MAX_OUT repeats per tick
        for (i = 0; i < KEYS; i++) begin
          if (step_res.size() < MAX_OUT && key_held[i] && it.now_time >= key_deadline[i]) begin
            step_res.push_back(ev(KIND_REPEAT, 8'(i), '0, it.now_time, 1'b0));
            key_deadline[i] = it.now_time + {16'd0, rep_period};
          end
        end
      end
    endcase
    if (step_res.size() > 0)
      step_res[step_res.size() - 1].last_of_run = 1'b1;
  endfunction

  function automatic void check_event(out_t got);
    out_t want;
    if (events_due.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected result: kind %0d key %0d payload %h stamp %h last %b",
                 got.out_kind, got.out_key, got.out_payload, got.out_stamp, got.last_of_run);
    end else begin
      want = events_due.pop_front();
      if (got.out_kind !== want.out_kind || got.out_key !== want.out_key ||
          got.out_payload !== want.out_payload || got.out_stamp !== want.out_stamp ||
          got.last_of_run !== want.last_of_run) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected kind %0d key %0d payload %h stamp %h last %b, ",
                   want.out_kind, want.out_key, want.out_payload, want.out_stamp,
                   want.last_of_run,
                   "got kind %0d key %0d payload %h stamp %h last %b",
                   got.out_kind, got.out_key, got.out_payload,
                   got.out_stamp, got.last_of_run);
      end
    end
  endfunction

  always @(posedge clk) begin
    int j;
    if (!rst_n) begin
      bounce_win = DEBOUNCE_RST;
      hold_delay = LONG_RST;
      rep_period = REPEAT_RST;
      for (j = 0; j < KEYS; j++) begin
        key_held[j] = 1'b0;
        key_last_press[j] = LAST_RESET;
        key_deadline[j] = '0;
      end
    end else begin
      if (out_valid && out_ready)
        check_event(out_data);
      if (cfg_we) begin
        case (cfg_index)
          REG_DEBOUNCE: bounce_win = cfg_wdata;
          REG_LONG:     hold_delay = cfg_wdata;
          REG_REPEAT:   rep_period = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        predict_events(in_data);
        if (in_chk.typed) begin
          if (in_chk.has_res)
            events_due.push_back(in_chk.res);
        end else begin
          foreach (step_res[n])
            events_due.push_back(step_res[n]);
        end
      end
    end
  end

  // result side: random backpressure, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= quiet || ($urandom_range(99) >= 26);
      end
    end
  end

  task automatic send_event(in_t item, dir_check_t chk);
    while (!quiet && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    in_chk <= chk;
    do @(posedge clk); while (!in_ready);
  endtask

  // drop valid, wait out every pending result and the tail of a silent item
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (events_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_timing(logic [15:0] win, logic [15:0] delay, logic [15:0] period);
    write_reg(REG_DEBOUNCE, win);
    write_reg(REG_LONG, delay);
    write_reg(REG_REPEAT, period);
  endtask

  function automatic in_t gen_item(int unsigned span);
    in_t it;
    int unsigned pick;
    pick = $urandom_range(99);
    if ($urandom_range(3) == 0)
      clock_ms += $urandom_range(span * 4);
    else
      clock_ms += $urandom_range(span / 4);
    it = pkt(FUNC_PRESS, 8'($urandom_range(KEYS - 1)), 3'($urandom_range(5)),
             $urandom, $urandom, clock_ms);
    if (pick < 30)
      it.func = FUNC_PRESS;
    else if (pick < 50)
      it.func = FUNC_RELEASE;
    else if (pick < 75)
      it.func = FUNC_TICK;
    else if (pick < 85) begin
      it.func = FUNC_PASS;
      it.pass_kind = 3'($urandom_range(7));
    end else begin
      // noise: any field value, time off the running clock
      it.func = 2'($urandom);
      it.key_num = 8'($urandom);
      it.pass_kind = 3'($urandom);
      it.now_time = $urandom;
    end
    return it;
  endfunction

  task automatic burst(int n, int unsigned span);
    repeat (n) send_event(gen_item(span), '0);
  endtask

  task automatic add_row(in_t item, logic typed, logic has_res, out_t res);
    dir_row_t r;
    r.item = item;
    r.chk.typed = typed;
    r.chk.has_res = has_res;
    r.chk.res = res;
    dir_rows.push_back(r);
  endtask

  initial begin
    int k;
    logic [31:0] pay;

    // after reset, key 0 at time 0 is 21 ms past its reset stamp
    add_row(pkt(FUNC_PRESS, 8'd0, 3'd0, 32'h0, 32'h0, 32'h0), 1'b1, 1'b1,
            ev(KIND_PRESS, 8'd0, 32'h0, 32'h0, 1'b1));
    add_row(pkt(FUNC_PRESS, 8'd0, 3'd0, 32'h0, 32'h1, 32'd5), 1'b1, 1'b0, '0);
    add_row(pkt(FUNC_PRESS, 8'd7, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd5), 1'b1, 1'b1,
            ev(KIND_PRESS, 8'd7, 32'h0, 32'hFFFF_FFFF, 1'b1));
    add_row(pkt(FUNC_PRESS, 8'd8, 3'd0, 32'h0, 32'h2, 32'd100), 1'b1, 1'b0, '0);
    add_row(pkt(FUNC_PRESS, 8'd255, 3'd7, 32'hFFFF_FFFF, 32'h3, 32'hFFFF_FFFF), 1'b1, 1'b0,
            '0);
    add_row(pkt(FUNC_RELEASE, 8'd3, 3'd0, 32'h0, 32'h4, 32'd6), 1'b1, 1'b0, '0);
    add_row(pkt(FUNC_RELEASE, 8'd255, 3'd0, 32'h0, 32'h5, 32'd6), 1'b1, 1'b0, '0);
    for (k = 0; k <= PASS_KIND_MAX; k++) begin
      pay = (k % 2 == 0) ? 32'hFFFF_FFFF - k : 32'hA5A5_0000 + k;
      add_row(pkt(FUNC_PASS, 8'hFF, 3'(k), pay, 32'h8000_0000 + k, 32'd7), 1'b1, 1'b1,
              ev(KIND_PASS_BASE + 4'(k), 8'd0, pay, 32'h8000_0000 + k, 1'b1));
    end
    add_row(pkt(FUNC_PASS, 8'd1, 3'd6, 32'h1234_5678, 32'h6, 32'd8), 1'b1, 1'b0, '0);
    add_row(pkt(FUNC_PASS, 8'd1, 3'd7, 32'h8765_4321, 32'h7, 32'd8), 1'b1, 1'b0, '0);
    add_row(pkt(FUNC_TICK, 8'd0, 3'd0, 32'h0, 32'h0, 32'd499), 1'b0, 1'b0, '0);
    add_row(pkt(FUNC_TICK, 8'd0, 3'd0, 32'h0, 32'h0, 32'd505), 1'b0, 1'b0, '0);
    add_row(pkt(FUNC_RELEASE, 8'd0, 3'd0, 32'h0, 32'h1234_5678, 32'd510), 1'b1, 1'b1,
            ev(KIND_RELEASE, 8'd0, 32'h0, 32'h1234_5678, 1'b1));
    // key already held, pressed again past the window: emitted and re-armed
    add_row(pkt(FUNC_PRESS, 8'd7, 3'd0, 32'h0, 32'h9, 32'd600), 1'b0, 1'b0, '0);
    // deadline wraps past 2^32 and fires on the next tick
    add_row(pkt(FUNC_PRESS, 8'd1, 3'd0, 32'h0, 32'hA, 32'hFFFF_FF00), 1'b0, 1'b0, '0);
    add_row(pkt(FUNC_TICK, 8'd0, 3'd0, 32'h0, 32'h0, 32'hFFFF_FF01), 1'b0, 1'b0, '0);
    add_row(pkt(FUNC_RELEASE, 8'd1, 3'd0, 32'h0, 32'hB, 32'hFFFF_FF02), 1'b0, 1'b0, '0);
    add_row(pkt(FUNC_RELEASE, 8'd7, 3'd0, 32'h0, 32'hC, 32'hFFFF_FF03), 1'b0, 1'b0, '0);
    add_row(pkt(FUNC_TICK, 8'd0, 3'd0, 32'h0, 32'h0, 32'hFFFF_FFFF), 1'b0, 1'b0, '0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r])
      send_event(dir_rows[r].item, dir_rows[r].chk);

    settle();
    set_timing(16'd0, 16'd0, 16'd0);
    clock_ms = 32'd1000;
    burst(80, 20);

    settle();
    set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
    clock_ms = 32'hFFFF_0000;
    burst(60, 20000);

    settle();
    set_timing(16'($urandom_range(40)), 16'($urandom_range(200)),
               16'($urandom_range(1, 60)));
    write_reg(REG_NONE, 16'($urandom));
    burst(40, 60);
    // stall the result side while items keep coming
    hold_req = 1'b1;
    burst(60, 60);

    settle();
    set_timing(16'($urandom), 16'($urandom), 16'($urandom));
    clock_ms = $urandom;
    burst(80, 2000);

    settle();
    set_timing(16'd20, 16'd120, 16'd30);
    quiet = 1'b1;
    burst(40, 40);
    quiet = 1'b0;
    burst(60, 40);

    settle();
    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
